// ===== hdl/dbfl_pkg.sv =====
// ----------------------------------------------------------------------------
// dbfl_pkg: shared types and constants for the detection box filter
// Widths, register indexes, sequencer states and fixed-point helpers.
// ----------------------------------------------------------------------------
package dbfl_pkg;

    localparam int CONF_W   = 16;
    localparam int EDGE_W   = 18;
    localparam int SIZE_W   = 12;
    localparam int CNT_W    = 9;
    localparam int SIDE_W   = 13;
    localparam int AREA_W   = 26;
    localparam int CRD_W    = 40;   // Q16 coordinate width
    localparam int PIX_W    = 22;   // whole-pixel intermediate width
    localparam int MUL_W    = 2 * PIX_W;
    localparam int FRAC_W   = 16;
    localparam int IN_W     = 88;
    localparam int OUT_W    = 64;
    localparam int CFG_A_W  = 2;
    localparam int CFG_D_W  = 16;

    localparam int MAX_ROWS  = 256;
    localparam int COUNT_MAX = (MAX_ROWS < 511) ? MAX_ROWS : 511;
    localparam int PIX_MAX   = 4095;
    localparam int SIDE_MIN  = -4096;
    localparam int TENTH_Q16 = 6554;
    localparam int AREA_MAX  = (1 << AREA_W) - 1;

    typedef enum logic [1:0] {
        REG_CONF_THR  = 2'd0,
        REG_MIN_SIDE  = 2'd1,
        REG_IMG_WIDTH = 2'd2,
        REG_IMG_HEIGHT = 2'd3
    } cfg_reg_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_MUL_X1,
        ST_MUL_Y1,
        ST_MUL_X2,
        ST_MUL_Y2,
        ST_SIZE,
        ST_CENTER,
        ST_SPAN,
        ST_MUL_T,
        ST_POS,
        ST_CLAMP,
        ST_MUL_A,
        ST_COMMIT
    } state_t;

    // Q16 to whole pixels, truncating toward zero
    function automatic logic signed [PIX_W-1:0] trunc_q16(input logic signed [CRD_W-1:0] v);
        logic signed [CRD_W-1:0] adj;
        adj = v + (v[CRD_W-1] ? CRD_W'((1 << FRAC_W) - 1) : CRD_W'(0));
        return adj[PIX_W+FRAC_W-1:FRAC_W];
    endfunction

    function automatic logic signed [PIX_W-1:0] max0(input logic signed [PIX_W-1:0] v);
        return v[PIX_W-1] ? PIX_W'(0) : v;
    endfunction

endpackage

// ===== hdl/detection_box_filter_largest.sv =====
// ----------------------------------------------------------------------------
// detection_box_filter_largest: largest-box filter for detector rows
// Filters, squares, clamps and ranks boxes of one frame; reports on last row.
// ----------------------------------------------------------------------------
// A row dropped on confidence goes from idle to commit, one dropped on size
// leaves after the center step and an accepted row runs every step; ready is
// low outside idle. The steps are set by the single shared 22x22 signed
// multiplier, which forms the four corner products, the tenth-of-span shift
// and the area one after another, with the add and clamp steps between them.
// A last row whose result cannot be loaded because the previous result is
// still waiting holds in its final step until the output register frees.
// Result fields are zero when no accepted box had positive area.
module detection_box_filter_largest
(
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           cfg_we,
    input  logic [dbfl_pkg::CFG_A_W-1:0]   cfg_addr,
    input  logic [dbfl_pkg::CFG_D_W-1:0]   cfg_wdata,
    input  logic                           s_tvalid,
    output logic                           s_tready,
    // confidence, left_edge, top_edge, right_edge, bottom_edge
    input  logic [dbfl_pkg::IN_W-1:0]      s_tdata,
    input  logic                           s_tlast,
    output logic                           m_tvalid,
    input  logic                           m_tready,
    // accepted_count, box_x, box_y, box_width, box_height, zero pad
    output logic [dbfl_pkg::OUT_W-1:0]     m_tdata,
    // box_valid
    output logic                           m_tuser
);
    import dbfl_pkg::*;

    state_t state_reg, state_next;

    logic [CONF_W-1:0] thr_reg;
    logic [SIZE_W-1:0] min_side_reg, img_w_reg, img_h_reg;

    logic signed [EDGE_W-1:0] left_reg, top_reg, right_reg, bottom_reg;
    logic last_reg, pass_reg;
    logic signed [CRD_W-1:0] x1_reg, y1_reg, x2_reg, y2_reg;
    logic signed [CRD_W-1:0] bw_reg, bh_reg, size_reg, nx_reg, ny_reg, t_reg;
    logic signed [PIX_W-1:0] span_reg, posx_reg, posy_reg, fw_reg, fh_reg;
    logic signed [MUL_W-1:0] area_reg;

    logic [CNT_W-1:0]  count_reg;
    logic [AREA_W-1:0] best_area_reg;
    logic              best_found_reg;
    logic [SIZE_W-1:0] best_x_reg, best_y_reg;
    logic [SIDE_W-1:0] best_w_reg, best_h_reg;

    logic              out_valid_reg, out_found_reg;
    logic [CNT_W-1:0]  out_cnt_reg;
    logic [SIZE_W-1:0] out_x_reg, out_y_reg;
    logic [SIDE_W-1:0] out_w_reg, out_h_reg;

    logic signed [PIX_W-1:0] mul_a, mul_b;
    logic signed [MUL_W-1:0] mul_p;
    logic signed [PIX_W-1:0] w_s, h_s;
    logic signed [CRD_W-1:0] min_q16;
    logic stall, commit_go, better;
    logic [AREA_W-1:0] area_sat;
    logic [CNT_W-1:0]  count_inc;
    logic [SIZE_W-1:0] cand_x, cand_y;
    logic [SIDE_W-1:0] cand_w, cand_h;

    assign w_s     = $signed({{(PIX_W-SIZE_W){1'b0}}, img_w_reg});
    assign h_s     = $signed({{(PIX_W-SIZE_W){1'b0}}, img_h_reg});
    assign min_q16 = $signed({{(CRD_W-SIZE_W-FRAC_W){1'b0}}, min_side_reg, {FRAC_W{1'b0}}});

    // shared multiplier
    always_comb
    begin
        mul_a = '0;
        mul_b = '0;
        unique case (state_reg)
            ST_MUL_X1: begin mul_a = PIX_W'(left_reg);   mul_b = w_s; end
            ST_MUL_Y1: begin mul_a = PIX_W'(top_reg);    mul_b = h_s; end
            ST_MUL_X2: begin mul_a = PIX_W'(right_reg);  mul_b = w_s; end
            ST_MUL_Y2: begin mul_a = PIX_W'(bottom_reg); mul_b = h_s; end
            ST_MUL_T:  begin mul_a = span_reg; mul_b = PIX_W'(TENTH_Q16); end
            ST_MUL_A:  begin mul_a = fw_reg;   mul_b = fh_reg; end
            default:   begin mul_a = '0;       mul_b = '0; end
        endcase
        mul_p = mul_a * mul_b;
    end

    // commit step
    always_comb
    begin
        area_sat  = (area_reg > MUL_W'(AREA_MAX)) ? AREA_W'(AREA_MAX) : area_reg[AREA_W-1:0];
        better    = pass_reg && (area_reg > 0) && (area_sat > best_area_reg);
        count_inc = (pass_reg && (count_reg < CNT_W'(COUNT_MAX))) ? count_reg + 1'b1 : count_reg;
        cand_x    = (posx_reg > PIX_W'(PIX_MAX)) ? SIZE_W'(PIX_MAX) : posx_reg[SIZE_W-1:0];
        cand_y    = (posy_reg > PIX_W'(PIX_MAX)) ? SIZE_W'(PIX_MAX) : posy_reg[SIZE_W-1:0];
        if (fw_reg > PIX_W'(PIX_MAX))
            cand_w = SIDE_W'(PIX_MAX);
        else if (fw_reg < PIX_W'(SIDE_MIN))
            cand_w = SIDE_W'(SIDE_MIN);
        else
            cand_w = fw_reg[SIDE_W-1:0];
        if (fh_reg > PIX_W'(PIX_MAX))
            cand_h = SIDE_W'(PIX_MAX);
        else if (fh_reg < PIX_W'(SIDE_MIN))
            cand_h = SIDE_W'(SIDE_MIN);
        else
            cand_h = fh_reg[SIDE_W-1:0];
    end

    assign stall     = last_reg && out_valid_reg && !m_tready;
    assign commit_go = (state_reg == ST_COMMIT) && !stall;

    always_comb
    begin
        state_next = state_reg;
        s_tready   = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                s_tready = 1'b1;
                if (s_tvalid)
                    state_next = (s_tdata[CONF_W-1:0] >= thr_reg) ? ST_MUL_X1 : ST_COMMIT;
            end
            ST_MUL_X1: state_next = ST_MUL_Y1;
            ST_MUL_Y1: state_next = ST_MUL_X2;
            ST_MUL_X2: state_next = ST_MUL_Y2;
            ST_MUL_Y2: state_next = ST_SIZE;
            ST_SIZE:   state_next = ST_CENTER;
            ST_CENTER: state_next = (size_reg < min_q16) ? ST_COMMIT : ST_SPAN;
            ST_SPAN:   state_next = ST_MUL_T;
            ST_MUL_T:  state_next = ST_POS;
            ST_POS:    state_next = ST_CLAMP;
            ST_CLAMP:  state_next = ST_MUL_A;
            ST_MUL_A:  state_next = ST_COMMIT;
            ST_COMMIT: state_next = stall ? ST_COMMIT : ST_IDLE;
            default:   state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= ST_IDLE;
        else
            state_reg <= state_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            thr_reg      <= CONF_W'(32768);
            min_side_reg <= SIZE_W'(40);
            img_w_reg    <= SIZE_W'(640);
            img_h_reg    <= SIZE_W'(480);
        end
        else if (cfg_we)
        begin
            unique case (cfg_reg_t'(cfg_addr))
                REG_CONF_THR:   thr_reg      <= cfg_wdata;
                REG_MIN_SIDE:   min_side_reg <= cfg_wdata[SIZE_W-1:0];
                REG_IMG_WIDTH:  img_w_reg    <= cfg_wdata[SIZE_W-1:0];
                REG_IMG_HEIGHT: img_h_reg    <= cfg_wdata[SIZE_W-1:0];
                default:        thr_reg      <= thr_reg;
            endcase
        end
    end

    // datapath
    always_ff @(posedge clk)
    begin
        case (state_reg)
            ST_IDLE:
            begin
                if (s_tvalid)
                begin
                    left_reg   <= $signed(s_tdata[33:16]);
                    top_reg    <= $signed(s_tdata[51:34]);
                    right_reg  <= $signed(s_tdata[69:52]);
                    bottom_reg <= $signed(s_tdata[87:70]);
                    last_reg   <= s_tlast;
                    pass_reg   <= s_tdata[CONF_W-1:0] >= thr_reg;
                end
            end
            ST_MUL_X1: x1_reg <= mul_p[CRD_W-1:0];
            ST_MUL_Y1: y1_reg <= mul_p[CRD_W-1:0];
            ST_MUL_X2: x2_reg <= mul_p[CRD_W-1:0];
            ST_MUL_Y2: y2_reg <= mul_p[CRD_W-1:0];
            ST_SIZE:
            begin
                bw_reg   <= x2_reg - x1_reg + CRD_W'(1 << FRAC_W);
                bh_reg   <= y2_reg - y1_reg + CRD_W'(1 << FRAC_W);
                size_reg <= (x2_reg - x1_reg + y2_reg - y1_reg + CRD_W'(2 << FRAC_W)) >>> 1;
            end
            ST_CENTER:
            begin
                if (size_reg < min_q16)
                    pass_reg <= 1'b0;
                nx_reg <= x1_reg + (bw_reg >>> 1) - (size_reg >>> 1);
                ny_reg <= y1_reg + (bh_reg >>> 1) - (size_reg >>> 1);
            end
            ST_SPAN:
            begin
                span_reg <= trunc_q16(y2_reg - ny_reg);
                posx_reg <= max0(trunc_q16(nx_reg));
                fw_reg   <= trunc_q16(x2_reg - nx_reg);
            end
            ST_MUL_T: t_reg <= mul_p[CRD_W-1:0];
            ST_POS:
            begin
                posy_reg <= max0(trunc_q16(ny_reg + t_reg));
                fh_reg   <= fw_reg;
                fw_reg   <= (posx_reg + fw_reg > w_s) ? w_s - posx_reg : fw_reg;
            end
            ST_CLAMP:
                fh_reg <= (posy_reg + fh_reg > h_s) ? h_s - posy_reg : fh_reg;
            ST_MUL_A: area_reg <= mul_p;
            default:  area_reg <= area_reg;
        endcase
    end

    // frame state and result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg      <= '0;
            best_area_reg  <= '0;
            best_found_reg <= 1'b0;
            best_x_reg     <= '0;
            best_y_reg     <= '0;
            best_w_reg     <= '0;
            best_h_reg     <= '0;
            out_valid_reg  <= 1'b0;
            out_found_reg  <= 1'b0;
            out_cnt_reg    <= '0;
            out_x_reg      <= '0;
            out_y_reg      <= '0;
            out_w_reg      <= '0;
            out_h_reg      <= '0;
        end
        else
        begin
            if (commit_go && last_reg)
                out_valid_reg <= 1'b1;
            else if (out_valid_reg && m_tready)
                out_valid_reg <= 1'b0;
            if (commit_go)
            begin
                if (last_reg)
                begin
                    out_cnt_reg    <= count_inc;
                    out_found_reg  <= better || best_found_reg;
                    out_x_reg      <= better ? cand_x : best_x_reg;
                    out_y_reg      <= better ? cand_y : best_y_reg;
                    out_w_reg      <= better ? cand_w : best_w_reg;
                    out_h_reg      <= better ? cand_h : best_h_reg;
                    count_reg      <= '0;
                    best_area_reg  <= '0;
                    best_found_reg <= 1'b0;
                    best_x_reg     <= '0;
                    best_y_reg     <= '0;
                    best_w_reg     <= '0;
                    best_h_reg     <= '0;
                end
                else
                begin
                    count_reg <= count_inc;
                    if (better)
                    begin
                        best_area_reg  <= area_sat;
                        best_found_reg <= 1'b1;
                        best_x_reg     <= cand_x;
                        best_y_reg     <= cand_y;
                        best_w_reg     <= cand_w;
                        best_h_reg     <= cand_h;
                    end
                end
            end
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tuser  = out_found_reg;
    assign m_tdata  = {5'b0, out_h_reg, out_w_reg, out_y_reg, out_x_reg, out_cnt_reg};

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(COUNT_MAX))
        else $error("row count above limit");

    a_found_area: assert property (@(posedge clk) disable iff (!rst_n)
        !best_found_reg |-> (best_area_reg == '0 && best_w_reg == '0 && best_x_reg == '0))
        else $error("best box held without a found flag");

    a_area_only_commit: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg != ST_COMMIT) |=> $stable(best_area_reg))
        else $error("best area changed outside commit");

    a_frame_clear: assert property (@(posedge clk) disable iff (!rst_n)
        (commit_go && last_reg) |=> (count_reg == '0 && !best_found_reg && out_valid_reg))
        else $error("frame not closed after last row");

    a_ready_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (s_tvalid && s_tready) |=> (state_reg != ST_IDLE))
        else $error("accepted item did not start the sequencer");

endmodule

// ===== bench/detection_box_filter_largest_test.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// detection_box_filter_largest_test: self-checking bench for the box filter
// Streams frames of detector rows under several register settings. A tracker
// class recomputes the largest clamped square box per frame. Every report is
// compared field by field against it, with random idling on both streams.
// ----------------------------------------------------------------------------
module detection_box_filter_largest_test;

    import dbfl_pkg::*;

    localparam longint UNIT        = 64'sd65536;
    localparam int     SETTLE      = 20;
    localparam int     CYCLE_LIMIT = 400000;

    typedef struct {
        logic [15:0]        conf;
        logic signed [17:0] left;
        logic signed [17:0] top;
        logic signed [17:0] right;
        logic signed [17:0] bottom;
        logic               last;
    } row_t;

    typedef struct {
        logic [8:0]         count;
        logic               valid;
        logic [11:0]        x;
        logic [11:0]        y;
        logic signed [12:0] w;
        logic signed [12:0] h;
    } report_t;

    class largest_box_tracker;
        int unsigned conf_thr;
        int unsigned min_side;
        int unsigned img_w;
        int unsigned img_h;
        int unsigned row_count;
        longint      best_area;
        bit          best_found;
        longint      best_x;
        longint      best_y;
        longint      best_w;
        longint      best_h;
        report_t     expected_reports[$];
        int          errors;
        int          reports_seen;

        function new();
            conf_thr = 32768;
            min_side = 40;
            img_w = 640;
            img_h = 480;
            errors = 0;
            reports_seen = 0;
            clear_frame();
        endfunction

        function void clear_frame();
            row_count = 0;
            best_area = 0;
            best_found = 0;
            best_x = 0;
            best_y = 0;
            best_w = 0;
            best_h = 0;
        endfunction

        function void set_reg(cfg_reg_t idx, int unsigned value);
            case (idx)
                REG_CONF_THR:   conf_thr = value & 32'hFFFF;
                REG_MIN_SIDE:   min_side = value & 32'hFFF;
                REG_IMG_WIDTH:  img_w = value & 32'hFFF;
                REG_IMG_HEIGHT: img_h = value & 32'hFFF;
                default:        ;
            endcase
        endfunction

        // floor division by two
        function longint floor_half(longint v);
            return v >>> 1;
        endfunction

        function longint clip(longint v, longint lo, longint hi);
            if (v < lo)
                return lo;
            if (v > hi)
                return hi;
            return v;
        endfunction

        function void note_row(row_t r);
            longint  w, h, x1, y1, x2, y2, bw, bh, side, nx, ny;
            longint  span, px, py, fw, fh, area;
            report_t rep;
            w = longint'(img_w);
            h = longint'(img_h);
            if (r.conf >= conf_thr)
            begin
                x1 = longint'(r.left) * w;
                y1 = longint'(r.top) * h;
                x2 = longint'(r.right) * w;
                y2 = longint'(r.bottom) * h;
                bw = x2 - x1 + UNIT;
                bh = y2 - y1 + UNIT;
                side = floor_half(bw + bh);
                if (side >= longint'(min_side) * UNIT)
                begin
                    nx = x1 + floor_half(bw) - floor_half(side);
                    ny = y1 + floor_half(bh) - floor_half(side);
                    // integer division truncates toward zero
                    span = (y2 - ny) / UNIT;
                    px = nx / UNIT;
                    py = (ny + span * TENTH_Q16) / UNIT;
                    fw = (x2 - nx) / UNIT;
                    fh = fw;
                    if (px < 0)
                        px = 0;
                    if (py < 0)
                        py = 0;
                    if (px + fw > w)
                        fw = w - px;
                    if (py + fh > h)
                        fh = h - py;
                    area = fw * fh;
                    if (area > 0)
                    begin
                        if (area > AREA_MAX)
                            area = AREA_MAX;
                        if (area > best_area)
                        begin
                            best_area = area;
                            best_found = 1;
                            best_x = clip(px, 0, PIX_MAX);
                            best_y = clip(py, 0, PIX_MAX);
                            best_w = clip(fw, SIDE_MIN, PIX_MAX);
                            best_h = clip(fh, SIDE_MIN, PIX_MAX);
                        end
                    end
                    if (row_count < COUNT_MAX)
                        row_count++;
                end
            end
            if (r.last)
            begin
                rep.count = row_count[8:0];
                rep.valid = best_found;
                rep.x = best_found ? best_x[11:0] : '0;
                rep.y = best_found ? best_y[11:0] : '0;
                rep.w = best_found ? best_w[12:0] : '0;
                rep.h = best_found ? best_h[12:0] : '0;
                expected_reports.push_back(rep);
                clear_frame();
            end
        endfunction

        function void compare_field(string what, longint want, longint got);
            if (want != got)
            begin
                errors++;
                $display("%0t: %s mismatch, expected %0d actual %0d", $time, what, want, got);
            end
        endfunction

        function void check_report(report_t got);
            report_t want;
            if (expected_reports.size() == 0)
            begin
                errors++;
                $display("%0t: unexpected report, count %0d", $time, got.count);
                return;
            end
            want = expected_reports.pop_front();
            reports_seen++;
            compare_field("accepted_count", want.count, got.count);
            compare_field("box_valid", want.valid, got.valid);
            compare_field("box_x", want.x, got.x);
            compare_field("box_y", want.y, got.y);
            compare_field("box_width", longint'(want.w), longint'(got.w));
            compare_field("box_height", longint'(want.h), longint'(got.h));
        endfunction
    endclass

    logic              clk = 1'b0;
    logic              rst_n = 1'b0;
    logic              cfg_we = 1'b0;
    logic [CFG_A_W-1:0] cfg_addr = '0;
    logic [CFG_D_W-1:0] cfg_wdata = '0;
    logic              s_tvalid = 1'b0;
    logic              s_tready;
    logic [IN_W-1:0]   s_tdata = '0;
    logic              s_tlast = 1'b0;
    logic              m_tvalid;
    logic              m_tready = 1'b0;
    logic [OUT_W-1:0]  m_tdata;
    logic              m_tuser;

    largest_box_tracker ranker = new();
    bit gaps_on = 1'b1;
    int rows_sent = 0;
    int frames_sent = 0;
    int settings_used = 0;
    int cycles = 0;
    int stall_left = 0;

    detection_box_filter_largest u_top
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tlast   (s_tlast),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        cycles++;
        if (cycles == CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles", cycles);
            $display("CHECKS FAILED");
            $finish;
        end
    end

    // result side back-pressure
    initial
    begin
        forever
        begin
            @(negedge clk);
            if (stall_left > 0)
            begin
                stall_left--;
                m_tready <= 1'b0;
            end
            else if (gaps_on && $urandom_range(0, 5) == 0)
            begin
                stall_left = $urandom_range(1, 9) - 1;
                m_tready <= 1'b0;
            end
            else
                m_tready <= 1'b1;
        end
    end

    always @(posedge clk)
    begin
        report_t got;
        if (rst_n && m_tvalid && m_tready)
        begin
            got.count = m_tdata[8:0];
            got.x = m_tdata[20:9];
            got.y = m_tdata[32:21];
            got.w = m_tdata[45:33];
            got.h = m_tdata[58:46];
            got.valid = m_tuser;
            ranker.check_report(got);
        end
    end

    function automatic row_t mk_row(int conf, int l, int t, int r, int b, bit last);
        row_t row;
        row.conf = 16'(conf);
        row.left = 18'(l);
        row.top = 18'(t);
        row.right = 18'(r);
        row.bottom = 18'(b);
        row.last = last;
        return row;
    endfunction

    // plausible box, confidence mostly at or above the threshold
    function automatic row_t box_row(int unsigned thr);
        int l, t, conf;
        l = int'($urandom_range(0, 72000)) - 8000;
        t = int'($urandom_range(0, 72000)) - 8000;
        if ($urandom_range(0, 4) == 0)
            conf = $urandom_range(0, 65535);
        else
            conf = $urandom_range(thr, 65535);
        return mk_row(conf, l, t, l + int'($urandom_range(0, 60000)),
                      t + int'($urandom_range(0, 60000)), 1'b0);
    endfunction

    function automatic row_t random_row(int unsigned thr);
        if ($urandom_range(0, 9) < 7)
            return box_row(thr);
        return mk_row($urandom, $urandom, $urandom, $urandom, $urandom, 1'b0);
    endfunction

    task automatic send_row(row_t r);
        if (gaps_on && $urandom_range(0, 3) == 0)
        begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 9)) @(negedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata <= {r.bottom, r.right, r.top, r.left, r.conf};
        s_tlast <= r.last;
        do
            @(posedge clk);
        while (!s_tready);
        ranker.note_row(r);
        rows_sent++;
        if (r.last)
            frames_sent++;
        @(negedge clk);
    endtask

    task automatic hold_until_drained(int settle);
        s_tvalid <= 1'b0;
        do
            @(negedge clk);
        while (ranker.expected_reports.size() != 0);
        repeat (settle) @(negedge clk);
    endtask

    task automatic load_config(int unsigned thr, int unsigned mins, int unsigned w,
                               int unsigned h);
        cfg_reg_t    regs[4];
        int unsigned vals[4];
        regs = '{REG_CONF_THR, REG_MIN_SIDE, REG_IMG_WIDTH, REG_IMG_HEIGHT};
        vals = '{thr, mins, w, h};
        for (int i = 0; i < 4; i++)
        begin
            cfg_we <= 1'b1;
            cfg_addr <= regs[i];
            cfg_wdata <= CFG_D_W'(vals[i]);
            ranker.set_reg(regs[i], vals[i]);
            @(negedge clk);
        end
        cfg_we <= 1'b0;
        settings_used++;
    endtask

    task automatic run_random_phase(int rows);
        int   done;
        int   len;
        row_t r;
        done = 0;
        while (done < rows)
        begin
            len = $urandom_range(1, 12);
            for (int i = 0; i < len; i++)
            begin
                r = random_row(ranker.conf_thr);
                r.last = (i == len - 1);
                send_row(r);
            end
            done += len;
            if ($urandom_range(0, 9) == 0)
                hold_until_drained(0);
        end
    endtask

    function automatic int unsigned pick_size();
        if ($urandom_range(0, 4) == 0)
            return $urandom_range(0, 1) ? 1 : 4095;
        return $urandom_range(1, 4095);
    endfunction

    initial
    begin
        row_t r;
        int unsigned thr, mins;
        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // reset settings: rejected last row gives an empty report
        send_row(mk_row(32767, 16384, 16384, 49152, 49152, 1'b1));
        send_row(mk_row(32768, 16384, 16384, 49152, 49152, 1'b0));
        send_row(mk_row(65535, 0, 0, 65536, 65536, 1'b0));
        send_row(mk_row(65535, 6554, 6554, 8000, 8000, 1'b0));
        // box past the right edge: width goes negative
        send_row(mk_row(65535, 98304, 26214, 131071, 39321, 1'b0));
        send_row(mk_row(50000, -131072, -131072, 131071, 131071, 1'b1));
        // equal-size boxes: the second is clipped at the bottom, so the first is kept
        send_row(mk_row(40000, 0, 0, 32768, 32768, 1'b0));
        send_row(mk_row(40000, 32768, 32768, 65536, 65536, 1'b1));
        send_row(mk_row(65535, 49152, 49152, 16384, 16384, 1'b0));
        send_row(mk_row(65535, 65536, 0, 81920, 16384, 1'b0));
        send_row(mk_row(0, 131071, 131071, -131072, -131072, 1'b1));
        hold_until_drained(SETTLE);

        load_config(0, 0, 4095, 4095);
        send_row(mk_row(0, -131072, -131072, 131071, 131071, 1'b0));
        send_row(mk_row(0, 131071, 131071, 131071, 131071, 1'b0));
        send_row(mk_row(0, 100000, 100000, 131071, 131071, 1'b0));
        send_row(mk_row(0, 0, 0, 0, 0, 1'b1));
        send_row(mk_row(65535, 120000, -131072, 131071, 131071, 1'b1));
        hold_until_drained(SETTLE);

        load_config(65535, 4095, 1, 1);
        send_row(mk_row(65535, 0, 0, 65536, 65536, 1'b0));
        send_row(mk_row(65534, -131072, -131072, 131071, 131071, 1'b1));
        hold_until_drained(SETTLE);

        // more accepted rows than the count can hold
        load_config(0, 0, 640, 480);
        for (int i = 0; i < 260; i++)
        begin
            r = box_row(0);
            r.last = (i == 259);
            send_row(r);
        end
        hold_until_drained(SETTLE);

        for (int p = 0; p < 8; p++)
        begin
            gaps_on = (p != 7);
            thr = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 65535) : $urandom_range(0, 40000);
            mins = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 4095) : $urandom_range(0, 60);
            load_config(thr, mins, pick_size(), pick_size());
            run_random_phase(48);
            hold_until_drained(SETTLE);
        end

        $display("Sent %0d rows in %0d frames under %0d register settings;", rows_sent,
                 frames_sent, settings_used + 1);
        $display("compared %0d reports, %0d field mismatches.", ranker.reports_seen,
                 ranker.errors);
        if (ranker.errors == 0 && ranker.expected_reports.size() == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule
